// ===== hw/rtl/sha_bsh_pkg.sv =====
package sha_bsh_pkg;

    typedef logic [31:0] t_word;

    // Element i holds hash word i.
    typedef logic [7:0][31:0] t_hash;

    localparam t_hash IV_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [3:0] LEN_HI_ADDR = 4'd14;
    localparam logic [3:0] LEN_LO_ADDR = 4'd15;
    localparam logic [5:0] POS_LAST    = 6'd63;
    localparam logic [5:0] POS_PAD_END = 6'd55;
    localparam logic [5:0] POS_LEN     = 6'd56;
    localparam logic [6:0] CNT_LAST    = 7'd65;
    localparam logic [6:0] CNT_SCHED_END = 7'd64;
    localparam logic [7:0] PAD_BYTE    = 8'h80;

    typedef struct packed {
        logic       we;
        logic [3:0] waddr;
        t_word      wdata;
        logic [3:0] raddr_a;
        logic [3:0] raddr_b;
    } t_wmem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN_HI,
        S_LEN_LO,
        S_COMP,
        S_WAIT,
        S_OUT
    } t_state;

    function automatic t_word big_sig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== hw/rtl/sha_bsh_ifs.sv =====
interface sha_bsh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface sha_bsh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [1:0]  word_number;
    logic        last_word;

    modport source (output valid, output digest_word, output word_number,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_number,
                    input last_word, output ready);
endinterface

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
// Channel | Dir | Payload                                  | Item
// i_in    | in  | data_byte, byte_present, end_of_message   | one message byte or end mark
// o_out   | out | digest_word, word_number, last_word      | 64 bits of the digest
//
// Data bytes are taken one per cycle while the block is idle; the 64th byte of a block
// starts a compression (a start state, the rounds through the single round unit,
// then a chain update), during which input is held off. An end mark adds the padding
// bytes, one per cycle, two length writes and one or two compressions. The digest is
// held in an output register, so the next message is taken while earlier digest
// words wait. Reset is synchronous, active low.
module sha256_byte_stream_hasher import sha_bsh_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha_bsh_in_if.sink    i_in,
    sha_bsh_out_if.source o_out
);

    t_state      r_state;
    t_state      n_state;
    logic        r_first;
    logic        n_first;
    logic        r_end_pend;
    logic        n_end_pend;
    logic        r_final;
    logic        n_final;

    logic [5:0]  r_pos;
    logic [23:0] r_acc;
    logic [63:0] r_bits;
    t_hash       r_chain;
    logic [255:0] r_dig;
    logic        r_ovalid;
    logic [1:0]  r_ocnt;

    logic        w_in_ready;
    logic        w_out_fire;
    logic        w_put;
    logic [7:0]  w_byte;
    logic        w_cnt_add;
    logic        w_start;
    logic        w_chain_add;
    logic        w_len_hi;
    logic        w_len_lo;
    logic        w_load_out;

    t_wmem_req   w_rnd_req;
    t_wmem_req   w_mem_req;
    t_word       w_rd_a;
    t_word       w_rd_b;
    logic        w_rnd_busy;
    logic        w_rnd_done;
    t_hash       w_vars;

    assign w_out_fire = r_ovalid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_first    <= 1'b0;
            r_end_pend <= 1'b0;
            r_final    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_first    <= n_first;
            r_end_pend <= n_end_pend;
            r_final    <= n_final;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_end_pend  = r_end_pend;
        n_final     = r_final;
        w_in_ready  = 1'b0;
        w_put       = 1'b0;
        w_byte      = 8'd0;
        w_cnt_add   = 1'b0;
        w_start     = 1'b0;
        w_chain_add = 1'b0;
        w_len_hi    = 1'b0;
        w_len_lo    = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready = i_rst_n;
                if (i_in.valid && i_rst_n) begin
                    if (i_in.byte_present) begin
                        w_put     = 1'b1;
                        w_byte    = i_in.data_byte;
                        w_cnt_add = 1'b1;
                    end
                    if (i_in.end_of_message) begin
                        n_first    = 1'b1;
                        n_end_pend = 1'b1;
                    end
                    if (i_in.byte_present && (r_pos == POS_LAST)) begin
                        n_state = S_COMP;
                    end else if (i_in.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                w_put   = 1'b1;
                w_byte  = r_first ? PAD_BYTE : 8'd0;
                n_first = 1'b0;
                if (r_pos == POS_PAD_END) begin
                    n_state = S_LEN_HI;
                end else if (r_pos == POS_LAST) begin
                    n_state = S_COMP;
                end
            end
            S_LEN_HI: begin
                w_len_hi = 1'b1;
                n_state  = S_LEN_LO;
            end
            S_LEN_LO: begin
                w_len_lo   = 1'b1;
                n_final    = 1'b1;
                n_end_pend = 1'b0;
                n_state    = S_COMP;
            end
            S_COMP: begin
                w_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_rnd_done) begin
                    w_chain_add = 1'b1;
                    if (r_final) begin
                        n_state = S_OUT;
                    end else if (r_end_pend) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    w_load_out = 1'b1;
                    n_final    = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 6'd0;
            r_bits  <= 64'd0;
            r_chain <= IV_HASH;
        end else begin
            if (w_put) begin
                r_pos <= r_pos + 6'd1;
            end
            if (w_cnt_add) begin
                r_bits <= r_bits + 64'd8;
            end
            if (w_chain_add) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + w_vars[i];
                end
            end
            if (w_load_out) begin
                r_pos   <= 6'd0;
                r_bits  <= 64'd0;
                r_chain <= IV_HASH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_acc <= {r_acc[15:0], w_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_ocnt   <= 2'd0;
        end else begin
            if (w_load_out) begin
                r_ovalid <= 1'b1;
                r_ocnt   <= 2'd0;
            end else if (w_out_fire) begin
                if (r_ocnt == 2'd3) begin
                    r_ovalid <= 1'b0;
                end
                r_ocnt <= r_ocnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            for (int i = 0; i < 8; i++) begin
                r_dig[255 - 32 * i -: 32] <= r_chain[i];
            end
        end else if (w_out_fire) begin
            r_dig <= {r_dig[191:0], 64'd0};
        end
    end

    always_comb begin
        w_mem_req = w_rnd_req;
        if (w_put && (r_pos[1:0] == 2'd3)) begin
            w_mem_req.we    = 1'b1;
            w_mem_req.waddr = r_pos[5:2];
            w_mem_req.wdata = {r_acc, w_byte};
        end else if (w_len_hi) begin
            w_mem_req.we    = 1'b1;
            w_mem_req.waddr = LEN_HI_ADDR;
            w_mem_req.wdata = r_bits[63:32];
        end else if (w_len_lo) begin
            w_mem_req.we    = 1'b1;
            w_mem_req.waddr = LEN_LO_ADDR;
            w_mem_req.wdata = r_bits[31:0];
        end
    end

    sha_bsh_wmem u_wmem (
        .i_clk  (i_clk),
        .i_req  (w_mem_req),
        .o_rd_a (w_rd_a),
        .o_rd_b (w_rd_b)
    );

    sha_bsh_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_chain (r_chain),
        .i_rd_a  (w_rd_a),
        .i_rd_b  (w_rd_b),
        .o_req   (w_rnd_req),
        .o_busy  (w_rnd_busy),
        .o_done  (w_rnd_done),
        .o_vars  (w_vars)
    );

    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = r_ovalid;
    assign o_out.digest_word = r_dig[255:192];
    assign o_out.word_number = r_ocnt;
    assign o_out.last_word   = (r_ocnt == 2'd3);

`ifndef NO_ASSERTIONS
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> !o_out.valid)
        else $error("Digest item still valid after its last word.");

    a_load_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> (r_pos == POS_LEN))
        else $error("Digest loaded before the length words were written.");

    a_no_load_write_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_put || w_len_hi || w_len_lo) |-> (!w_rnd_busy && !w_rnd_done))
        else $error("Block write while the round unit owns the memory.");
`endif

endmodule

// ===== hw/rtl/sha_bsh_wmem.sv =====
module sha_bsh_wmem import sha_bsh_pkg::*; (
    input  logic      i_clk,
    input  t_wmem_req i_req,
    output t_word     o_rd_a,
    output t_word     o_rd_b
);

    t_word mem [16];
    t_word r_rd_a;
    t_word r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_a <= mem[i_req.raddr_a];
        r_rd_b <= mem[i_req.raddr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// ===== hw/rtl/sha_bsh_round.sv =====
module sha_bsh_round import sha_bsh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_hash     i_chain,
    input  t_word     i_rd_a,
    input  t_word     i_rd_b,
    output t_wmem_req o_req,
    output logic      o_busy,
    output logic      o_done,
    output t_hash     o_vars
);

    logic       r_run;
    logic       r_done;
    logic [6:0] r_cnt;
    t_word      r_prev_a;
    t_word      r_w1;
    t_word      r_w2;
    t_hash      r_vars;

    logic [6:0] w_j;
    logic [6:0] w_t;
    logic       w_sched;
    logic       w_round;
    t_word      w_wnew;
    t_word      w_t1;
    t_word      w_t2;
    t_word      w_ch;
    t_word      w_maj;

    // Reads are issued ahead of the schedule stage through the memory's read registers,
    // and the schedule stage feeds the round stage through r_w1.
    assign w_j     = r_cnt - 7'd1;
    assign w_t     = r_cnt - 7'd2;
    assign w_sched = r_run && (r_cnt >= 7'd1) && (r_cnt <= CNT_SCHED_END);
    assign w_round = r_run && (r_cnt >= 7'd2);

    always_comb begin
        if (w_j[6:4] == 3'd0) begin
            w_wnew = i_rd_b;
        end else begin
            w_wnew = small_sig1(r_w2) + i_rd_b + small_sig0(i_rd_a) + r_prev_a;
        end
    end

    always_comb begin
        o_req.we      = w_sched && (w_j[6:4] != 3'd0);
        o_req.waddr   = w_j[3:0];
        o_req.wdata   = w_wnew;
        o_req.raddr_a = r_cnt[3:0] + 4'd1;
        if (r_cnt[6:4] == 3'd0) begin
            o_req.raddr_b = r_cnt[3:0];
        end else begin
            o_req.raddr_b = r_cnt[3:0] + 4'd9;
        end
    end

    assign w_ch  = (r_vars[4] & r_vars[5]) ^ (~r_vars[4] & r_vars[6]);
    assign w_maj = (r_vars[0] & r_vars[1]) ^ (r_vars[0] & r_vars[2])
                 ^ (r_vars[1] & r_vars[2]);
    assign w_t1  = r_vars[7] + big_sig1(r_vars[4]) + w_ch + ROUND_K[w_t[5:0]] + r_w1;
    assign w_t2  = big_sig0(r_vars[0]) + w_maj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 7'd0;
            end else if (r_run) begin
                if (r_cnt == CNT_LAST) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_vars <= i_chain;
        end else if (w_round) begin
            r_vars <= {r_vars[6], r_vars[5], r_vars[4], r_vars[3] + w_t1,
                       r_vars[2], r_vars[1], r_vars[0], w_t1 + w_t2};
        end
        if (w_sched) begin
            r_prev_a <= i_rd_a;
            r_w1     <= w_wnew;
            r_w2     <= r_w1;
        end
    end

    assign o_busy = r_run;
    assign o_done = r_done;
    assign o_vars = r_vars;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!r_run && !r_done))
        else $error("Compression started while one is in progress.");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_cnt <= CNT_LAST))
        else $error("Round counter ran past the last round.");

    a_no_raw_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.we |-> ((o_req.waddr != o_req.raddr_a) && (o_req.waddr != o_req.raddr_b)))
        else $error("Schedule write collides with a pending read.");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_run) && !r_run))
        else $error("Done raised without a finished compression.");
`endif

endmodule

// ===== tb/sha_digest_checker.sv =====
module sha_digest_checker import sha_bsh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sha_bsh_in_if   i_in_ch,
    sha_bsh_out_if  i_out_ch,
    output int      o_error_count,
    output int      o_words_pending,
    output int      o_words_checked
);

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  index;
        logic        is_last;
    } t_digest_word;

    t_hash         chain_words;
    t_word         sched[16];
    logic [63:0]   bit_count;
    t_digest_word  expected_words[$];
    t_digest_word  oldest;
    int            errors;
    int            checked;

    function automatic t_word ror32(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic store_byte(input int pos, input logic [7:0] b);
        if (pos % 4 == 0) begin
            sched[pos / 4] = {b, 24'h000000};
        end else begin
            sched[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
        end
    endtask

    task automatic compress_block();
        t_word v[8];
        t_word w, x15, x2, t1, t2;
        for (int i = 0; i < 8; i++) begin
            v[i] = chain_words[i];
        end
        for (int t = 0; t < 64; t++) begin
            if (t >= 16) begin
                x15 = sched[(t - 15) & 15];
                x2  = sched[(t - 2) & 15];
                sched[t & 15] = sched[t & 15]
                    + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3))
                    + sched[(t - 7) & 15]
                    + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
            end
            w  = sched[t & 15];
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            chain_words[i] = chain_words[i] + v[i];
        end
    endtask

    // Updates the running hash with one item and queues the four digest
    // words when the item ends a message.
    task automatic absorb_item(input logic [7:0] b, input logic present, input logic ends);
        int          pos;
        logic [63:0] len;
        if (present) begin
            pos = int'(bit_count[8:3]);
            store_byte(pos, b);
            bit_count = bit_count + 64'd8;
            if (pos == 63) begin
                compress_block();
            end
        end
        if (ends) begin
            len = bit_count;
            pos = int'(len[8:3]);
            store_byte(pos, 8'h80);
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    store_byte(pos, 8'h00);
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56) begin
                store_byte(pos, 8'h00);
                pos++;
            end
            sched[14] = len[63:32];
            sched[15] = len[31:0];
            compress_block();
            for (int k = 0; k < 4; k++) begin
                expected_words.insert(expected_words.size(),
                    t_digest_word'{value: {chain_words[2 * k], chain_words[2 * k + 1]},
                                   index: 2'(k), is_last: (k == 3)});
            end
            chain_words = IV_HASH;
            bit_count = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chain_words = IV_HASH;
            bit_count = '0;
            for (int i = 0; i < 16; i++) begin
                sched[i] = '0;
            end
            expected_words.delete();
        end else begin
            // Results are checked before the item of this edge is absorbed, so a
            // digest word can never match an expectation queued in the same cycle.
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $error("digest word %h arrived with no message ended", i_out_ch.digest_word);
                    errors++;
                end else begin
                    oldest = expected_words.pop_front();
                    if (i_out_ch.digest_word !== oldest.value) begin
                        $error("digest_word: expected %h, actual %h",
                               oldest.value, i_out_ch.digest_word);
                        errors++;
                    end
                    if (i_out_ch.word_number !== oldest.index) begin
                        $error("word_number: expected %0d, actual %0d",
                               oldest.index, i_out_ch.word_number);
                        errors++;
                    end
                    if (i_out_ch.last_word !== oldest.is_last) begin
                        $error("last_word: expected %b, actual %b",
                               oldest.is_last, i_out_ch.last_word);
                        errors++;
                    end
                    checked++;
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                absorb_item(i_in_ch.data_byte, i_in_ch.byte_present, i_in_ch.end_of_message);
            end
        end
        o_error_count   <= errors;
        o_words_pending <= expected_words.size();
        o_words_checked <= checked;
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;

    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int TAIL_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 10;

    logic i_clk;
    logic i_rst_n;

    sha_bsh_in_if  in_ch();
    sha_bsh_out_if out_ch();

    int error_count;
    int words_pending;
    int words_checked;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_output;
    int quiet_cycles;

    int messages_sent;
    int bytes_sent;
    int ignored_sent;
    int phase_items;

    int boundary_lengths[6] = '{55, 56, 57, 63, 64, 65};

    sha256_byte_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sha_digest_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_ch         (in_ch),
        .i_out_ch        (out_ch),
        .o_error_count   (error_count),
        .o_words_pending (words_pending),
        .o_words_checked (words_checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The output side either stalls at random or, on request, holds ready low
    // for a long stretch so that the block backs up into its input.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_output = 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic present, input logic ends);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.byte_present   <= present;
        in_ch.end_of_message <= ends;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    // The end mark rides on the last byte or comes as an item of its own;
    // items with neither flag are scattered in as noise.
    task automatic send_message(input int n_bytes);
        bit end_alone;
        end_alone = (n_bytes == 0) || ($urandom_range(1) == 1);
        for (int i = 0; i < n_bytes; i++) begin
            if ($urandom_range(9) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
                ignored_sent++;
            end
            send_item(8'($urandom), 1'b1, (i == n_bytes - 1) && !end_alone);
        end
        if (end_alone) begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
        messages_sent++;
        bytes_sent  += n_bytes;
        phase_items += n_bytes + int'(end_alone);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_items    = 0;
        while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(99) < 75) begin
                send_message($urandom_range(10));
            end else begin
                send_message(boundary_lengths[$urandom_range(5)]);
            end
        end
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= 8'h00;
        in_ch.byte_present   <= 1'b0;
        in_ch.end_of_message <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_output    = 1'b0;
        messages_sent  = 0;
        bytes_sent     = 0;
        ignored_sent   = 0;
        phase_items    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'ha5, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        messages_sent += 4;
        bytes_sent    += 5;
        ignored_sent  += 2;

        run_phase(0, 0);
        run_phase(85, 0);
        run_phase(0, 85);
        run_phase(38, 38);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_output    = 1'b1;
        repeat (4) begin
            send_message($urandom_range(6));
        end
        in_ch.valid <= 1'b0;

        do begin
            @(posedge i_clk);
        end while (words_pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages, %0d bytes, %0d ignored items; %0d digest words checked.",
                 messages_sent, bytes_sent, ignored_sent, words_checked);
        $display("Idling covered none, sender only, receiver only, both, and one long output hold.");
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sha_bsh_pkg.sv
hw/rtl/sha_bsh_ifs.sv
hw/rtl/sha_bsh_wmem.sv
hw/rtl/sha_bsh_round.sv
hw/rtl/sha256_byte_stream_hasher.sv
tb/sha_digest_checker.sv
tb/testbench.sv
